@@ sv/ffsa_pkg.sv @@
// Shared types and constants of the first-fit segment allocator.
`default_nettype none

package ffsa_pkg;

  localparam int unsigned MAX_SEGMENTS = 16;
  localparam int unsigned ADDR_W       = 16;
  localparam int unsigned OWNER_W      = 8;
  localparam int unsigned PADDR_W      = 2;
  localparam int unsigned PDATA_W      = 32;

  localparam logic [ADDR_W-1:0] CAP_RESET = 16'hFFFF;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_FIT   = 2'd1,
    ST_NO_OWNER = 2'd2,
    ST_FULL     = 2'd3
  } status_e;

  typedef struct packed {
    op_e                opcode;
    logic [OWNER_W-1:0] owner_id;
    logic [ADDR_W-1:0]  request_size;
  } in_item_t;

  typedef struct packed {
    status_e           status;
    logic [ADDR_W-1:0] start_address;
    logic [ADDR_W-1:0] free_total;
  } out_item_t;

  typedef struct packed {
    logic               valid;
    logic               used;
    logic [OWNER_W-1:0] owner;
    logic [ADDR_W-1:0]  start;
    logic [ADDR_W-1:0]  size;
  } seg_t;

  typedef struct packed {
    seg_t seg;
    logic sel;
  } link_t;

  typedef struct packed {
    logic [ADDR_W-1:0] start;
    logic [ADDR_W-1:0] size;
  } pick_t;

  typedef enum logic [2:0] {
    CMD_HOLD,
    CMD_INIT,
    CMD_HIT,
    CMD_SEL,
    CMD_TAKE,
    CMD_SPLIT,
    CMD_FREE
  } cmd_e;

  typedef struct packed {
    cmd_e               cmd;
    op_e                op;
    logic [OWNER_W-1:0] owner;
    logic [ADDR_W-1:0]  size;
    logic [ADDR_W-1:0]  cap;
  } cell_ctl_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_HIT,
    S_SEL,
    S_DEC,
    S_UPD
  } state_e;

endpackage

`default_nettype wire

@@ sv/first_fit_segment_allocator.sv @@
// First-fit segment allocator: top level with sequencer, register port and cell row.
`default_nettype none

// A row of 16 cells holds the segment table in address order, one segment per
// cell. An item is taken only when the block is idle; after acceptance it passes
// through match, first-hit chain through the row, decision, and update with a
// one-place shift for a split, the update waiting while the output side holds an
// unread result. The next item can be accepted in the cycle after the result
// register is loaded, so a new item is never taken before the last one is done.
// Each of those steps is one registered state. After reset and after every
// write of the capacity register the table re-initialises once the block is
// idle, and no item is accepted until that is done.

module first_fit_segment_allocator (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  ffsa_pkg::in_item_t                  in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output ffsa_pkg::out_item_t                 out_data_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [ffsa_pkg::PADDR_W-1:0]        paddr,
  input  logic [ffsa_pkg::PDATA_W-1:0]        pwdata,
  output logic [ffsa_pkg::PDATA_W-1:0]        prdata,
  output logic                                pready
);
  import ffsa_pkg::*;

  state_e            state_q, state_d;
  logic [ADDR_W-1:0] cap_q;
  logic              init_q;
  logic [ADDR_W-1:0] avail_q, avail_d;
  in_item_t          req_q;
  status_e           status_q, status_d;
  logic              split_q, split_d;
  pick_t             pick_q;
  out_item_t         out_q, out_d;
  logic              out_valid_q, out_valid_d;
  cell_ctl_t         ctl;
  logic              cfg_wr;
  logic              in_acc;
  logic              found;
  logic              full;

  link_t link   [MAX_SEGMENTS+1];
  logic  seen   [MAX_SEGMENTS+1];
  pick_t pickc  [MAX_SEGMENTS+1];

  assign link[0]  = '0;
  assign seen[0]  = 1'b0;
  assign pickc[0] = '0;

  for (genvar g = 0; g < MAX_SEGMENTS; g++) begin : g_cell
    ffsa_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .head_i (g == 0),
      .ctl_i  (ctl),
      .left_i (link[g]),
      .seen_i (seen[g]),
      .pick_i (pickc[g]),
      .link_o (link[g+1]),
      .seen_o (seen[g+1]),
      .pick_o (pickc[g+1])
    );
  end

  assign pready = 1'b1;
  assign prdata = PDATA_W'(cap_q);
  assign cfg_wr = psel && penable && pwrite && pready;

  assign in_ready_o = (state_q == S_IDLE) && !init_q;
  assign in_acc     = in_valid_i && in_ready_o;
  assign found      = seen[MAX_SEGMENTS];
  assign full       = link[MAX_SEGMENTS].seg.valid;

  always_comb begin
    state_d     = state_q;
    avail_d     = avail_q;
    status_d    = status_q;
    split_d     = split_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    ctl.cmd     = CMD_HOLD;
    ctl.op      = req_q.opcode;
    ctl.owner   = req_q.owner_id;
    ctl.size    = req_q.request_size;
    ctl.cap     = cap_q;
    case (state_q)
      S_IDLE: begin
        if (init_q) begin
          ctl.cmd = CMD_INIT;
          avail_d = cap_q;
        end else if (in_acc) begin
          state_d = S_HIT;
        end
      end
      S_HIT: begin
        ctl.cmd = CMD_HIT;
        state_d = S_SEL;
      end
      S_SEL: begin
        ctl.cmd = CMD_SEL;
        state_d = S_DEC;
      end
      S_DEC: begin
        split_d = pickc[MAX_SEGMENTS].size != req_q.request_size;
        if (req_q.opcode == OP_ALLOC) begin
          if (!found) begin
            status_d = ST_NO_FIT;
          end else if (split_d && full) begin
            status_d = ST_FULL;
          end else begin
            status_d = ST_OK;
          end
        end else begin
          status_d = found ? ST_OK : ST_NO_OWNER;
        end
        state_d = S_UPD;
      end
      S_UPD: begin
        if (!out_valid_q || out_ready_i) begin
          out_d.status        = status_q;
          out_d.start_address = '0;
          if (status_q == ST_OK) begin
            out_d.start_address = pick_q.start;
            if (req_q.opcode == OP_ALLOC) begin
              ctl.cmd = split_q ? CMD_SPLIT : CMD_TAKE;
              avail_d = avail_q - req_q.request_size;
            end else begin
              ctl.cmd = CMD_FREE;
              avail_d = avail_q + pick_q.size;
            end
          end
          out_d.free_total = avail_d;
          out_valid_d      = 1'b1;
          state_d          = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cap_q       <= CAP_RESET;
      init_q      <= 1'b1;
      avail_q     <= CAP_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      avail_q     <= avail_d;
      out_valid_q <= out_valid_d;
      if (cfg_wr) begin
        cap_q  <= pwdata[ADDR_W-1:0];
        init_q <= 1'b1;
      end else if (state_q == S_IDLE) begin
        init_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    split_q  <= split_d;
    out_q    <= out_d;
    if (in_acc) begin
      req_q <= in_data_i;
    end
    if (state_q == S_DEC) begin
      pick_q <= pickc[MAX_SEGMENTS];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

@@ sv/ffsa_cell.sv @@
// One segment slot of the allocator row: match, first-hit chain and shift.
`default_nettype none

module ffsa_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                head_i,
  input  ffsa_pkg::cell_ctl_t ctl_i,
  input  ffsa_pkg::link_t     left_i,
  input  logic                seen_i,
  input  ffsa_pkg::pick_t     pick_i,
  output ffsa_pkg::link_t     link_o,
  output logic                seen_o,
  output ffsa_pkg::pick_t     pick_o
);
  import ffsa_pkg::*;

  seg_t seg_q, seg_d;
  logic hit_q, hit_d;
  logic sel_q, sel_d;
  logic beyond_q, beyond_d;
  logic match;

  always_comb begin
    if (ctl_i.op == OP_ALLOC) begin
      match = seg_q.valid && !seg_q.used && (seg_q.size >= ctl_i.size);
    end else begin
      match = seg_q.valid && seg_q.used && (seg_q.owner == ctl_i.owner);
    end
  end

  always_comb begin
    seg_d    = seg_q;
    hit_d    = hit_q;
    sel_d    = sel_q;
    beyond_d = beyond_q;
    case (ctl_i.cmd)
      CMD_INIT: begin
        seg_d.valid = head_i;
        seg_d.used  = 1'b0;
        seg_d.start = '0;
        seg_d.size  = ctl_i.cap;
      end
      CMD_HIT: begin
        hit_d = match;
      end
      CMD_SEL: begin
        sel_d    = hit_q && !seen_i;
        beyond_d = seen_i;
      end
      CMD_TAKE: begin
        if (sel_q) begin
          seg_d.used  = 1'b1;
          seg_d.owner = ctl_i.owner;
        end
      end
      CMD_SPLIT: begin
        if (sel_q) begin
          seg_d.used  = 1'b1;
          seg_d.owner = ctl_i.owner;
          seg_d.size  = ctl_i.size;
        end else if (left_i.sel) begin
          // remainder of the split segment
          seg_d.valid = 1'b1;
          seg_d.used  = 1'b0;
          seg_d.owner = '0;
          seg_d.start = left_i.seg.start + ctl_i.size;
          seg_d.size  = left_i.seg.size - ctl_i.size;
        end else if (beyond_q) begin
          seg_d = left_i.seg;
        end
      end
      CMD_FREE: begin
        if (sel_q) begin
          seg_d.used  = 1'b0;
          seg_d.owner = '0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_q    <= '0;
      hit_q    <= 1'b0;
      sel_q    <= 1'b0;
      beyond_q <= 1'b0;
    end else begin
      seg_q    <= seg_d;
      hit_q    <= hit_d;
      sel_q    <= sel_d;
      beyond_q <= beyond_d;
    end
  end

  assign link_o.seg = seg_q;
  assign link_o.sel = sel_q;
  assign seen_o     = seen_i || hit_q;
  assign pick_o     = sel_q ? (pick_i | pick_t'{start: seg_q.start, size: seg_q.size}) : pick_i;

endmodule

`default_nettype wire

@@ tb/sv/ffsa_result_checker.sv @@
// Watches the allocator's channels and register port, predicts each reply and compares.
module ffsa_result_checker #(
  parameter logic [ffsa_pkg::PADDR_W-1:0] CAP_ADDR = '0
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic                         in_ready_i,
  input  ffsa_pkg::in_item_t           in_data_i,
  input  logic                         out_valid_i,
  input  logic                         out_ready_i,
  input  ffsa_pkg::out_item_t          out_data_i,
  input  logic                         psel_i,
  input  logic                         penable_i,
  input  logic                         pwrite_i,
  input  logic                         pready_i,
  input  logic [ffsa_pkg::PADDR_W-1:0] paddr_i,
  input  logic [ffsa_pkg::PDATA_W-1:0] pwdata_i,
  output int                           fail_count_o,
  output int                           pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import ffsa_pkg::*;

  logic [ADDR_W-1:0]  seg_start [MAX_SEGMENTS];
  logic [ADDR_W-1:0]  seg_size  [MAX_SEGMENTS];
  logic [OWNER_W-1:0] seg_owner [MAX_SEGMENTS];
  logic               seg_used  [MAX_SEGMENTS];
  int                 seg_count;
  logic [ADDR_W-1:0]  units_free;

  out_item_t predicted_replies [$];
  out_item_t want;

  initial fail_count_o = 0;

  task automatic report(input string what, input logic [31:0] exp, input logic [31:0] got);
    $display("[%0t] mismatch on %s: expected %0h, got %0h", $time, what, exp, got);
    fail_count_o++;
  endtask

  function automatic void load_capacity(input logic [ADDR_W-1:0] cap);
    int j;
    for (j = 0; j < MAX_SEGMENTS; j++) begin
      seg_start[j] = '0;
      seg_size[j]  = '0;
      seg_owner[j] = '0;
      seg_used[j]  = 1'b0;
    end
    seg_size[0] = cap;
    seg_count   = 1;
    units_free  = cap;
  endfunction

  function automatic out_item_t serve_request(input in_item_t req);
    out_item_t res;
    int        hit;
    int        j;
    res.status        = ST_OK;
    res.start_address = '0;
    hit               = -1;
    if (req.opcode == OP_ALLOC) begin
      for (j = 0; j < seg_count; j++) begin
        if (hit < 0 && !seg_used[j] && seg_size[j] >= req.request_size) hit = j;
      end
      if (hit < 0) begin
        res.status = ST_NO_FIT;
      end else if (seg_size[hit] != req.request_size && seg_count >= MAX_SEGMENTS) begin
        res.status = ST_FULL;
      end else begin
        if (seg_size[hit] != req.request_size) begin
          // open a slot after the hit for the remainder
          for (j = seg_count; j > hit + 1; j--) begin
            seg_start[j] = seg_start[j-1];
            seg_size[j]  = seg_size[j-1];
            seg_owner[j] = seg_owner[j-1];
            seg_used[j]  = seg_used[j-1];
          end
          seg_start[hit+1] = seg_start[hit] + req.request_size;
          seg_size[hit+1]  = seg_size[hit] - req.request_size;
          seg_owner[hit+1] = '0;
          seg_used[hit+1]  = 1'b0;
          seg_size[hit]    = req.request_size;
          seg_count++;
        end
        seg_used[hit]     = 1'b1;
        seg_owner[hit]    = req.owner_id;
        units_free        = units_free - req.request_size;
        res.start_address = seg_start[hit];
      end
    end else begin
      for (j = 0; j < seg_count; j++) begin
        if (hit < 0 && seg_used[j] && seg_owner[j] == req.owner_id) hit = j;
      end
      if (hit < 0) begin
        res.status = ST_NO_OWNER;
      end else begin
        seg_used[hit]     = 1'b0;
        seg_owner[hit]    = '0;
        units_free        = units_free + seg_size[hit];
        res.start_address = seg_start[hit];
      end
    end
    res.free_total = units_free;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      predicted_replies.delete();
      load_capacity(CAP_RESET);
      pending_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (predicted_replies.size() == 0) begin
          report("reply with none outstanding", '0, 32'(out_data_i));
        end else begin
          want = predicted_replies.pop_front();
          if (out_data_i.status !== want.status)
            report("status", want.status, out_data_i.status);
          if (out_data_i.start_address !== want.start_address)
            report("start_address", want.start_address, out_data_i.start_address);
          if (out_data_i.free_total !== want.free_total)
            report("free_total", want.free_total, out_data_i.free_total);
        end
      end
      if (psel_i && penable_i && pwrite_i && pready_i && paddr_i == CAP_ADDR)
        load_capacity(pwdata_i[ADDR_W-1:0]);
      if (in_valid_i && in_ready_i)
        predicted_replies.push_back(serve_request(in_data_i));
      pending_o <= predicted_replies.size();
    end
  end

endmodule

@@ tb/sv/tb_first_fit_segment_allocator.sv @@
// Stimulus, register set-up and verdict for the first-fit segment allocator.
module tb_first_fit_segment_allocator;
  timeunit 1ns;
  timeprecision 1ps;
  import ffsa_pkg::*;

  localparam logic [PADDR_W-1:0] CAPACITY_ADDR = '0;
  localparam int CYCLE_LIMIT = 500000;
  localparam int N_PHASES    = 12;
  localparam int PHASE_ITEMS = 152;
  localparam int LONG_HOLD   = 400;
  localparam int SETTLE      = 10;

  typedef enum int {RX_FLOWING, RX_CHOPPY, RX_SPARSE} rx_mode_e;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  in_item_t           in_data_i;
  logic               out_valid_o;
  logic               out_ready_i;
  out_item_t          out_data_o;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  int       fail_count;
  int       pending;
  int       cycles;
  int       burst_left;
  int       cap_now;
  bit       hold_req;
  int       hold_left;
  int       mode_left;
  rx_mode_e rx_mode;

  int phase_caps [N_PHASES] = '{1, 65535, 40, 16, 200, 0, 65535, 1, 1000, 0, 17, 300};

  first_fit_segment_allocator dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  ffsa_result_checker #(.CAP_ADDR(CAPACITY_ADDR)) result_chk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_i  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_i (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_i  (out_data_o),
    .psel_i      (psel),
    .penable_i   (penable),
    .pwrite_i    (pwrite),
    .pready_i    (pready),
    .paddr_i     (paddr),
    .pwdata_i    (pwdata),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // receiver: long hold on request, otherwise stretches of differing stall density
  always @(posedge clk_i) begin
    if (hold_req) begin
      hold_left = LONG_HOLD;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        rx_mode   = rx_mode_e'($urandom_range(2));
        mode_left = $urandom_range(10, 80);
      end
      mode_left--;
      case (rx_mode)
        RX_FLOWING: out_ready_i <= 1'b1;
        RX_CHOPPY:  out_ready_i <= 1'($urandom_range(1));
        default:    out_ready_i <= ($urandom_range(9) != 0);
      endcase
    end
  end

  function automatic in_item_t mk(input op_e op, input int owner, input int size);
    in_item_t it;
    it.opcode       = op;
    it.owner_id     = OWNER_W'(owner);
    it.request_size = ADDR_W'(size);
    return it;
  endfunction

  task automatic offer(input in_item_t it);
    int gap;
    in_data_i  <= it;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap        = $urandom_range(6);
      burst_left = $urandom_range(24);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  task automatic drain_replies();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_capacity(input int cap);
    drain_replies();
    write_reg(CAPACITY_ADDR, PDATA_W'(cap));
    cap_now = cap;
  endtask

  task automatic run_phase(input int n_items, input int pause_at);
    in_item_t req;
    int       i;
    int       pick;
    int       k;
    int       sz;
    for (i = 0; i < n_items; i++) begin
      req.opcode   = ($urandom_range(99) < 55) ? OP_ALLOC : OP_FREE;
      req.owner_id = ($urandom_range(7) == 0) ? OWNER_W'($urandom_range(255))
                                              : OWNER_W'($urandom_range(5));
      pick = $urandom_range(9);
      if (pick < 4) begin
        sz = $urandom_range(1, 6);
      end else if (pick < 7) begin
        sz = $urandom_range(0, cap_now / 4);
      end else if (pick == 7) begin
        sz = 0;
      end else if (pick == 8) begin
        sz = $urandom_range(65535);
      end else begin
        k  = $urandom_range(3);
        sz = (cap_now > k) ? cap_now - k : 0;
      end
      req.request_size = ADDR_W'(sz);
      offer(req);
      if (i == pause_at) drain_replies();
    end
  endtask

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("Verification failed");
    $finish;
  end

  initial begin
    int ph;
    int cap;
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    in_data_i   <= '0;
    out_ready_i <= 1'b0;
    psel        <= 1'b0;
    penable     <= 1'b0;
    pwrite      <= 1'b0;
    paddr       <= '0;
    pwdata      <= '0;
    burst_left  = 0;
    hold_req    = 1'b0;
    hold_left   = 0;
    mode_left   = 0;
    cap_now     = 65535;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // whole space, no fit, unknown owner, free, zero-size split
    offer(mk(OP_ALLOC, 0, 65535));
    offer(mk(OP_ALLOC, 1, 1));
    offer(mk(OP_FREE, 255, 0));
    offer(mk(OP_FREE, 0, 65535));
    offer(mk(OP_ALLOC, 255, 0));
    offer(mk(OP_FREE, 255, 12345));

    // fill the table with splits, then refuse a split and take an exact fit
    set_capacity(17);
    for (int n = 1; n <= 15; n++) offer(mk(OP_ALLOC, n, 1));
    offer(mk(OP_ALLOC, 16, 1));
    offer(mk(OP_ALLOC, 17, 2));

    // empty pool
    set_capacity(0);
    offer(mk(OP_ALLOC, 0, 0));
    offer(mk(OP_ALLOC, 3, 1));

    for (ph = 0; ph < N_PHASES; ph++) begin
      cap = (phase_caps[ph] == 0) ? $urandom_range(1, 65535) : phase_caps[ph];
      set_capacity(cap);
      if (ph == 1) hold_req = 1'b1;
      run_phase(PHASE_ITEMS, (ph == 3) ? 70 : -1);
    end

    drain_replies();
    repeat (SETTLE) @(posedge clk_i);
    if (fail_count == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule

@@ sim.f @@
sv/ffsa_pkg.sv
sv/ffsa_cell.sv
sv/first_fit_segment_allocator.sv
tb/sv/ffsa_result_checker.sv
tb/sv/tb_first_fit_segment_allocator.sv
